// ===== sv/pwrm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwrm_pkg
// Shared types and constants for the pulse width reciprocal meter.
// ----------------------------------------------------------------------------
package pwrm_pkg;

  localparam int COUNT_BITS = 32;
  localparam int DATA_W     = 32;
  localparam int DIV_STEPS  = DATA_W;
  localparam int CNT_W      = $clog2(DIV_STEPS);
  localparam int READ_W     = 17;
  localparam int DIGITS     = 5;
  localparam int BCD_W      = 4 * DIGITS;

  localparam logic [READ_W-1:0] READ_MAX = READ_W'(99999);

  localparam logic [DATA_W-1:0] SCALE_RST = DATA_W'(72000000);
  localparam logic [DATA_W-1:0] LIMIT_RST = DATA_W'(60000);
  localparam logic [DATA_W-1:0] WMIN_RST  = DATA_W'(721);
  localparam logic [DATA_W-1:0] WMAX_RST  = DATA_W'(35999);

  typedef logic [3:0]            digit_t;
  typedef logic [DATA_W-1:0]     word_t;
  typedef logic [COUNT_BITS-1:0] count_t;

  typedef enum logic [1:0] {
    REG_SCALE = 2'd0,
    REG_LIMIT = 2'd1,
    REG_WMIN  = 2'd2,
    REG_WMAX  = 2'd3
  } reg_idx_t;

endpackage
`default_nettype wire

// ===== sv/pwrm_in_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwrm_in_if
// Capture timestamp request channel.
// ----------------------------------------------------------------------------
interface pwrm_in_if;
  logic                  valid;
  logic                  ready;
  pwrm_pkg::word_t       capture_time;

  modport source (output valid, output capture_time, input ready);
  modport sink   (input valid, input capture_time, output ready);
endinterface
`default_nettype wire

// ===== sv/pwrm_out_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwrm_out_if
// Reading result channel: range flag, five BCD digits and measured width.
// ----------------------------------------------------------------------------
interface pwrm_out_if;
  logic              valid;
  logic              ready;
  logic              in_range;
  pwrm_pkg::digit_t  digit_tens;
  pwrm_pkg::digit_t  digit_units;
  pwrm_pkg::digit_t  digit_tenths;
  pwrm_pkg::digit_t  digit_hundredths;
  pwrm_pkg::digit_t  digit_thousandths;
  pwrm_pkg::word_t   pulse_width;

  modport source (output valid, output in_range, output digit_tens, output digit_units,
                  output digit_tenths, output digit_hundredths, output digit_thousandths,
                  output pulse_width, input ready);
  modport sink   (input valid, input in_range, input digit_tens, input digit_units,
                  input digit_tenths, input digit_hundredths, input digit_thousandths,
                  input pulse_width, output ready);
endinterface
`default_nettype wire

// ===== sv/pwrm_cfg_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pwrm_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface pwrm_cfg_if;
  logic                valid;
  logic                ready;
  pwrm_pkg::reg_idx_t  index;
  pwrm_pkg::word_t     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/pulse_width_reciprocal_meter.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pulse_width_reciprocal_meter
// Pulse high-width meter with reciprocal reading in BCD digits.
// ----------------------------------------------------------------------------
// Capture requests alternate rising and falling edge. A rising-edge request
// only records its timestamp and gives no result. A falling-edge request
// gives no result when the width is zero or at/above the limit. When the
// width is outside the display window it skips the divider and gives an
// out-of-range result with all digits zero. Otherwise the quotient comes
// from a restoring divider retiring one bit per cycle, then a shift-and-add-3
// converter builds the digits one bit per cycle.
// The result waits in an output register; the next request is taken meanwhile.
// Registers may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module pulse_width_reciprocal_meter (
  input  wire          clk,
  input  wire          rst_n,
  pwrm_in_if.sink      in_ch,
  pwrm_out_if.source   out_ch,
  pwrm_cfg_if.sink     cfg_ch
);
  import pwrm_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_CHK  = 5'b00010,
    S_DIV  = 5'b00100,
    S_BCD  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic               fall_r, fall_nxt;
  count_t             rise_r, rise_nxt;
  count_t             width_r, width_nxt;
  logic               shown_r, shown_nxt;
  count_t             rem_r, rem_nxt;
  word_t              quo_r, quo_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [READ_W-1:0]  bin_r, bin_nxt;
  logic [BCD_W-1:0]   bcd_r, bcd_nxt;

  word_t              scale_r, limit_r, wmin_r, wmax_r;

  logic               ov_r, ov_nxt;
  logic               o_range_r;
  logic [BCD_W-1:0]   o_bcd_r;
  count_t             o_width_r;

  logic               in_acc, load_out;
  count_t             stamp;
  logic [COUNT_BITS:0] trial;
  logic [COUNT_BITS:0] shifted;
  logic [BCD_W-1:0]   adj;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign stamp        = in_ch.capture_time[COUNT_BITS-1:0];
  assign load_out     = (state_r == S_DONE) && (!ov_r || out_ch.ready);

  assign shifted = {rem_r, quo_r[DATA_W-1]};
  assign trial   = shifted - {1'b0, width_r};

  always_comb begin
    adj = bcd_r;
    for (int d = 0; d < DIGITS; d++) begin
      if (bcd_r[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd_r[4*d +: 4] + 4'd3;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    fall_nxt  = fall_r;
    rise_nxt  = rise_r;
    width_nxt = width_r;
    shown_nxt = shown_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    bin_nxt   = bin_r;
    bcd_nxt   = bcd_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (!fall_r) begin
            rise_nxt = stamp;
            fall_nxt = 1'b1;
          end else begin
            fall_nxt  = 1'b0;
            width_nxt = stamp - rise_r;
            state_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        shown_nxt = (word_t'(width_r) >= wmin_r) && (word_t'(width_r) <= wmax_r);
        rem_nxt   = '0;
        quo_nxt   = scale_r;
        bcd_nxt   = '0;
        bin_nxt   = '0;
        cnt_nxt   = CNT_W'(READ_W - 1);
        if (width_r == '0 || word_t'(width_r) >= limit_r) begin
          state_nxt = S_IDLE;
        end else if ((word_t'(width_r) >= wmin_r) && (word_t'(width_r) <= wmax_r)) begin
          cnt_nxt   = CNT_W'(DIV_STEPS - 1);
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_BCD;
        end
      end
      S_DIV: begin
        if (!trial[COUNT_BITS]) begin
          rem_nxt = trial[COUNT_BITS-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_nxt = shifted[COUNT_BITS-1:0];
          quo_nxt = {quo_r[DATA_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          cnt_nxt   = CNT_W'(READ_W - 1);
          state_nxt = S_BCD;
          if (quo_nxt > word_t'(READ_MAX)) begin
            bin_nxt = READ_MAX;
          end else begin
            bin_nxt = quo_nxt[READ_W-1:0];
          end
        end
      end
      S_BCD: begin
        bcd_nxt = {adj[BCD_W-2:0], bin_r[READ_W-1]};
        bin_nxt = {bin_r[READ_W-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (load_out) begin
      ov_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      fall_r  <= 1'b0;
      ov_r    <= 1'b0;
      scale_r <= SCALE_RST;
      limit_r <= LIMIT_RST;
      wmin_r  <= WMIN_RST;
      wmax_r  <= WMAX_RST;
    end else begin
      state_r <= state_nxt;
      fall_r  <= fall_nxt;
      ov_r    <= ov_nxt;
      if (cfg_ch.valid) begin
        case (cfg_ch.index)
          REG_SCALE: scale_r <= cfg_ch.data;
          REG_LIMIT: limit_r <= cfg_ch.data;
          REG_WMIN:  wmin_r  <= cfg_ch.data;
          REG_WMAX:  wmax_r  <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    rise_r  <= rise_nxt;
    width_r <= width_nxt;
    shown_r <= shown_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    cnt_r   <= cnt_nxt;
    bin_r   <= bin_nxt;
    bcd_r   <= bcd_nxt;
    if (load_out) begin
      o_range_r <= shown_r;
      o_bcd_r   <= bcd_r;
      o_width_r <= width_r;
    end
  end

  assign out_ch.valid             = ov_r;
  assign out_ch.in_range          = o_range_r;
  assign out_ch.digit_tens        = o_bcd_r[19:16];
  assign out_ch.digit_units       = o_bcd_r[15:12];
  assign out_ch.digit_tenths      = o_bcd_r[11:8];
  assign out_ch.digit_hundredths  = o_bcd_r[7:4];
  assign out_ch.digit_thousandths = o_bcd_r[3:0];
  assign out_ch.pulse_width       = word_t'(o_width_r);

endmodule
`default_nettype wire
